FILE: sv/lbfm_pkg.sv
// lbfm_pkg: shared constants and tables for the lorentz boost block
// no dependencies

package lbfm_pkg;

    localparam int MOMENTUM_WIDTH = 32;
    localparam int BETA_W         = 31;
    localparam int COEF_W         = 32;
    localparam int CF             = 20;
    localparam int NCOEF          = 10;
    localparam int TAG_W          = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BETA_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_Z = 2'd2;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd1 <<< CF;

    // coefficient order: tt, tx, ty, tz, xx, yy, zz, xy, xz, yz
    // rows x, y, z, e; columns x, y, z, e
    localparam logic [3:0] ROW_IDX [4][4] = '{
        '{4'd4, 4'd7, 4'd8, 4'd1},
        '{4'd7, 4'd5, 4'd9, 4'd2},
        '{4'd8, 4'd9, 4'd6, 4'd3},
        '{4'd1, 4'd2, 4'd3, 4'd0}
    };

    // beta products for the spatial coefficients
    localparam logic [1:0] PAIR_I [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
    localparam logic [1:0] PAIR_J [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
    localparam logic [3:0] PAIR_DST [6] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9};

endpackage

FILE: sv/lorentz_boost_four_momentum.sv
// lorentz_boost_four_momentum: streaming general lorentz boost of four-momenta
// depends on lbfm_pkg; holds the coefficient engine and the product pipeline
//
// stages p1 to o5; one beat per cycle except during output stalls and rebuilds
// a beta write starts a coefficient rebuild (restoring divide, bitwise
// square root, second divide, shared 34x34 multiplier); s_axis_tready is low meanwhile
// reset: beta zero, identity matrix, beta valid, pipeline empty

module lorentz_boost_four_momentum #(
    parameter int MOMENTUM_WIDTH = lbfm_pkg::MOMENTUM_WIDTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // mom_x, mom_y, mom_z, energy_in, tag_in, zero pad
    input  logic [((4*MOMENTUM_WIDTH+lbfm_pkg::TAG_W+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_x, out_y, out_z, energy_out, tag_out, zero pad
    output logic [((4*MOMENTUM_WIDTH+lbfm_pkg::TAG_W+7)/8)*8-1:0] m_axis_tdata,
    // beta_invalid, saturated
    output logic [1:0] m_axis_tuser,
    input  logic cfg_wr_en,
    input  logic [lbfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbfm_pkg::BETA_W-1:0] cfg_data
);

    localparam int W   = MOMENTUM_WIDTH;
    localparam int TW  = lbfm_pkg::TAG_W;
    localparam int DW  = ((4*W+TW+7)/8)*8;
    localparam int LW  = W/2;
    localparam int HW  = W-LW;
    localparam int CW  = lbfm_pkg::COEF_W;
    localparam int CF  = lbfm_pkg::CF;
    localparam int HPW = HW+CW;
    localparam int LPW = LW+1+CW;
    localparam int HSW = HPW+2;
    localparam int LSW = LPW+2;
    localparam int AW  = W+CW+4;
    localparam int RW  = AW-CF;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQ, ST_CHK, ST_DIV, ST_SQRT, ST_KDIV, ST_MUL
    } state_t;

    // ---------------- coefficient engine ----------------
    state_t state_reg;
    logic signed [30:0] beta_reg [3];
    logic signed [CW-1:0] coef_reg [lbfm_pkg::NCOEF];
    logic beta_ok_reg;
    logic [6:0] cnt_reg;
    logic [61:0] b2_reg;
    logic [60:0] d_reg;
    logic [60:0] rem_reg;
    logic [62:0] q_reg;
    logic [62:0] g2_reg;
    logic [63:0] sv_reg, sr_reg, sbit_reg;
    logic [31:0] g_reg;
    logic [33:0] krem_reg;
    logic [33:0] k_reg;
    logic signed [31:0] qv_reg;
    logic [3:0] ci_reg;
    logic [1:0] ph_reg;
    logic signed [67:0] prod_reg;

    logic signed [33:0] ma, mb;
    logic [2:0] qi;
    logic [61:0] rem2;
    logic [62:0] sum_rb;
    logic [63:0] sr_next;
    logic [33:0] krem2, kdv;
    logic signed [67:0] rnd_prod;
    logic signed [67:0] coef_wide;

    function automatic logic signed [CW-1:0] clamp32(input logic signed [67:0] v);
        if (v > 68'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -68'sd2147483648)
            return 32'sh80000000;
        else
            return v[CW-1:0];
    endfunction

    assign qi       = 3'(ci_reg - 4'd3);
    assign rnd_prod = (prod_reg + (68'sd1 <<< 29)) >>> 30;
    assign rem2     = {rem_reg, 1'b0};
    assign krem2    = {krem_reg[32:0], g2_reg[6'(7'd62 - cnt_reg)]};
    assign kdv      = {2'b00, g_reg} + (34'd1 << CF);
    assign sum_rb   = 63'(sr_reg + sbit_reg);

    always_comb
    begin
        if (sv_reg >= 64'(sum_rb))
            sr_next = (sr_reg >> 1) + sbit_reg;
        else
            sr_next = sr_reg >> 1;
    end

    always_comb
    begin
        ma = 34'(beta_reg[0]);
        mb = 34'(beta_reg[0]);
        if (state_reg == ST_SQ && cnt_reg < 7'd3)
        begin
            ma = 34'(beta_reg[cnt_reg[1:0]]);
            mb = 34'(beta_reg[cnt_reg[1:0]]);
        end
        else if (state_reg == ST_MUL)
        begin
            if (ci_reg < 4'd3)
            begin
                ma = $signed({2'b00, g_reg});
                mb = 34'(beta_reg[ci_reg[1:0]]);
            end
            else if (ph_reg == 2'd0)
            begin
                ma = 34'(beta_reg[lbfm_pkg::PAIR_I[qi]]);
                mb = 34'(beta_reg[lbfm_pkg::PAIR_J[qi]]);
            end
            else
            begin
                ma = $signed({1'b0, k_reg[32:0]});
                mb = 34'(qv_reg);
            end
        end
    end

    always_comb
    begin
        if (ci_reg < 4'd3)
            coef_wide = -rnd_prod;
        else if (lbfm_pkg::PAIR_I[qi] == lbfm_pkg::PAIR_J[qi])
            coef_wide = rnd_prod + 68'(lbfm_pkg::COEF_ONE);
        else
            coef_wide = rnd_prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            beta_ok_reg <= 1'b1;
            cnt_reg     <= '0;
            b2_reg      <= '0;
            d_reg       <= '0;
            rem_reg     <= '0;
            q_reg       <= '0;
            g2_reg      <= '0;
            sv_reg      <= '0;
            sr_reg      <= '0;
            sbit_reg    <= '0;
            g_reg       <= '0;
            krem_reg    <= '0;
            k_reg       <= '0;
            qv_reg      <= '0;
            ci_reg      <= '0;
            ph_reg      <= '0;
            prod_reg    <= '0;
            for (int i = 0; i < 3; i++)
                beta_reg[i] <= '0;
            for (int i = 0; i < lbfm_pkg::NCOEF; i++)
                coef_reg[i] <= (i == 0 || i >= 4 && i <= 6) ? lbfm_pkg::COEF_ONE : '0;
        end
        else
        begin
            prod_reg <= ma * mb;
            // a beta register write (re)starts the rebuild from any state
            if (cfg_wr_en && (cfg_index inside {lbfm_pkg::REG_BETA_X, lbfm_pkg::REG_BETA_Y,
                                                lbfm_pkg::REG_BETA_Z}))
            begin
                unique case (cfg_index)
                    lbfm_pkg::REG_BETA_X:
                    begin
                        beta_reg[0] <= $signed(cfg_data);
                    end
                    lbfm_pkg::REG_BETA_Y:
                    begin
                        beta_reg[1] <= $signed(cfg_data);
                    end
                    lbfm_pkg::REG_BETA_Z:
                    begin
                        beta_reg[2] <= $signed(cfg_data);
                    end
                    default:
                    begin
                    end
                endcase
                state_reg <= ST_SQ;
                cnt_reg   <= '0;
                b2_reg    <= '0;
            end
            else
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        state_reg <= ST_IDLE;
                    end
                    ST_SQ:
                    begin
                        if (cnt_reg != 7'd0)
                            b2_reg <= b2_reg + prod_reg[61:0];
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd3)
                            state_reg <= ST_CHK;
                    end
                    ST_CHK:
                    begin
                        cnt_reg <= '0;
                        if (b2_reg >= (62'd1 << 60))
                        begin
                            beta_ok_reg <= 1'b0;
                            for (int i = 0; i < lbfm_pkg::NCOEF; i++)
                                coef_reg[i] <= (i == 0 || i >= 4 && i <= 6) ?
                                               lbfm_pkg::COEF_ONE : '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            beta_ok_reg <= 1'b1;
                            d_reg   <= 61'((62'd1 << 60) - b2_reg);
                            rem_reg <= 61'd1;
                            q_reg   <= '0;
                            if (61'((62'd1 << 60) - b2_reg) < (61'd1 << 38))
                            begin
                                g2_reg    <= 63'd1 << 62;
                                sv_reg    <= 64'd1 << 62;
                                sr_reg    <= '0;
                                sbit_reg  <= 64'd1 << 62;
                                state_reg <= ST_SQRT;
                            end
                            else
                            begin
                                state_reg <= ST_DIV;
                            end
                        end
                    end
                    ST_DIV:
                    begin
                        if (rem2 >= {1'b0, d_reg})
                        begin
                            rem_reg <= 61'(rem2 - {1'b0, d_reg});
                            q_reg   <= {q_reg[61:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem2[60:0];
                            q_reg   <= {q_reg[61:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd99)
                        begin
                            g2_reg    <= (rem2 >= {1'b0, d_reg}) ? {q_reg[61:0], 1'b1} :
                                                                  {q_reg[61:0], 1'b0};
                            sv_reg    <= {1'b0, (rem2 >= {1'b0, d_reg}) ?
                                                {q_reg[61:0], 1'b1} : {q_reg[61:0], 1'b0}};
                            sr_reg    <= '0;
                            sbit_reg  <= 64'd1 << 62;
                            cnt_reg   <= '0;
                            state_reg <= ST_SQRT;
                        end
                    end
                    ST_SQRT:
                    begin
                        if (sv_reg >= 64'(sum_rb))
                            sv_reg <= sv_reg - 64'(sum_rb);
                        sr_reg   <= sr_next;
                        sbit_reg <= sbit_reg >> 2;
                        cnt_reg  <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd31)
                        begin
                            g_reg     <= sr_next[31:0];
                            krem_reg  <= '0;
                            k_reg     <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_KDIV;
                        end
                    end
                    ST_KDIV:
                    begin
                        if (krem2 >= kdv)
                        begin
                            krem_reg <= krem2 - kdv;
                            k_reg    <= {k_reg[32:0], 1'b1};
                        end
                        else
                        begin
                            krem_reg <= krem2;
                            k_reg    <= {k_reg[32:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd62)
                        begin
                            coef_reg[0] <= clamp32(68'($signed({1'b0, g_reg})));
                            ci_reg      <= '0;
                            ph_reg      <= '0;
                            state_reg   <= ST_MUL;
                        end
                    end
                    ST_MUL:
                    begin
                        ph_reg <= ph_reg + 2'd1;
                        if (ci_reg < 4'd3 && ph_reg == 2'd1)
                        begin
                            coef_reg[4'(ci_reg + 4'd1)] <= clamp32(coef_wide);
                            ci_reg <= ci_reg + 4'd1;
                            ph_reg <= '0;
                        end
                        else if (ci_reg >= 4'd3 && ph_reg == 2'd1)
                        begin
                            qv_reg <= rnd_prod[31:0];
                        end
                        else if (ci_reg >= 4'd3 && ph_reg == 2'd3)
                        begin
                            coef_reg[lbfm_pkg::PAIR_DST[qi]] <= clamp32(coef_wide);
                            ci_reg <= ci_reg + 4'd1;
                            if (ci_reg == 4'd8)
                                state_reg <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    // ---------------- product pipeline ----------------
    logic ce;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic inv1_reg, inv2_reg, inv3_reg, inv4_reg, inv5_reg;
    logic [TW-1:0] tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic signed [W-1:0] p1_reg [4];
    logic signed [W-1:0] p2_reg [4];
    logic signed [W-1:0] p3_reg [4];
    logic signed [W-1:0] p4_reg [4];
    logic signed [HPW-1:0] hp2_reg [4][4];
    logic signed [LPW-1:0] lp2_reg [4][4];
    logic signed [HSW-1:0] hs3_reg [4];
    logic signed [LSW-1:0] ls3_reg [4];
    logic signed [RW-1:0] r4_reg [4];
    logic [W-1:0] o5_reg [4];
    logic sat5_reg;

    logic signed [HSW-1:0] hs_next [4];
    logic signed [LSW-1:0] ls_next [4];
    logic signed [AW-1:0] acc_next [4];
    logic [W-1:0] o_next [4];
    logic sat_next;

    localparam logic signed [RW-1:0] MAXV = RW'((64'sd1 <<< (W-1)) - 64'sd1);
    localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);

    assign ce            = !v5_reg || m_axis_tready;
    assign s_axis_tready = ce && (state_reg == ST_IDLE);

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            hs_next[r] = '0;
            ls_next[r] = '0;
            for (int c = 0; c < 4; c++)
            begin
                hs_next[r] = hs_next[r] + HSW'(hp2_reg[r][c]);
                ls_next[r] = ls_next[r] + LSW'(lp2_reg[r][c]);
            end
            acc_next[r] = (AW'(hs3_reg[r]) <<< LW) + AW'(ls3_reg[r])
                          + (AW'(1) <<< (CF-1));
        end
    end

    always_comb
    begin
        sat_next = 1'b0;
        for (int r = 0; r < 4; r++)
        begin
            if (inv4_reg)
                o_next[r] = p4_reg[r];
            else if (r4_reg[r] > MAXV)
            begin
                o_next[r] = MAXV[W-1:0];
                sat_next  = 1'b1;
            end
            else if (r4_reg[r] < MINV)
            begin
                o_next[r] = MINV[W-1:0];
                sat_next  = 1'b1;
            end
            else
                o_next[r] = r4_reg[r][W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= s_axis_tvalid && s_axis_tready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 4; i++)
                p1_reg[i] <= $signed(s_axis_tdata[i*W +: W]);
            tag1_reg <= s_axis_tdata[4*W +: TW];
            inv1_reg <= !beta_ok_reg;

            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                begin
                    hp2_reg[r][c] <= HPW'($signed(p1_reg[c][W-1:LW]))
                                     * HPW'(coef_reg[lbfm_pkg::ROW_IDX[r][c]]);
                    lp2_reg[r][c] <= LPW'($signed({1'b0, p1_reg[c][LW-1:0]}))
                                     * LPW'(coef_reg[lbfm_pkg::ROW_IDX[r][c]]);
                end
            p2_reg   <= p1_reg;
            tag2_reg <= tag1_reg;
            inv2_reg <= inv1_reg;

            hs3_reg  <= hs_next;
            ls3_reg  <= ls_next;
            p3_reg   <= p2_reg;
            tag3_reg <= tag2_reg;
            inv3_reg <= inv2_reg;

            for (int r = 0; r < 4; r++)
                r4_reg[r] <= RW'(acc_next[r] >>> CF);
            p4_reg   <= p3_reg;
            tag4_reg <= tag3_reg;
            inv4_reg <= inv3_reg;

            o5_reg   <= o_next;
            sat5_reg <= sat_next && !inv4_reg;
            tag5_reg <= tag4_reg;
            inv5_reg <= inv4_reg;
        end
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tuser  = {sat5_reg, inv5_reg};
    assign m_axis_tdata  = DW'({tag5_reg, o5_reg[3], o5_reg[2], o5_reg[1], o5_reg[0]});

    // ---------------- checks ----------------
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken during coefficient rebuild");

    a_rebuild_by_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ && $past(state_reg) == ST_IDLE) |-> $past(cfg_wr_en))
        else $error("rebuild started without a register write");

    a_invalid_identity: assert property (@(posedge clk) disable iff (!rst_n)
        !beta_ok_reg |-> (coef_reg[0] == lbfm_pkg::COEF_ONE && coef_reg[1] == '0))
        else $error("matrix not identity while beta invalid");

    a_inv_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[1])
        else $error("saturation flagged on pass-through beat");

endmodule

FILE: verif/lorentz_boost_four_momentum_tb.sv
// lorentz_boost_four_momentum_tb: checks the four-momentum boost stream against its own
// fixed-point boost predictor over several beta settings, with random gaps and stalls
// depends on lbfm_pkg and lorentz_boost_four_momentum

module lorentz_boost_four_momentum_tb;

    localparam int MW = lbfm_pkg::MOMENTUM_WIDTH;
    localparam int TGW = lbfm_pkg::TAG_W;
    localparam int DW = ((4*MW+TGW+7)/8)*8;
    localparam longint unsigned ONE60 = 64'd1 << 60;

    typedef struct {
        logic signed [MW-1:0] mom [4];
        logic [TGW-1:0] tag;
    } particle_t;

    typedef struct {
        logic signed [MW-1:0] mom [4];
        logic [TGW-1:0] tag;
        logic invalid;
        logic sat;
    } boosted_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [DW-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic cfg_wr_en;
    logic [lbfm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lbfm_pkg::BETA_W-1:0] cfg_data;

    particle_t pending_particles [$];
    particle_t shown_particle;
    boosted_t expected_boosts [$];
    longint beta_val [3];
    longint coef [lbfm_pkg::NCOEF];
    bit beta_good;
    bit in_taken;
    bit fail_seen;
    bit sender_dense;
    int gap_left;
    int hold_left;
    int hold_request;

    lorentz_boost_four_momentum dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rnd_shift(longint v, int n);
        return (v + (64'sd1 <<< (n-1))) >>> n;
    endfunction

    function automatic string comp_name(int i);
        case (i)
            0: return "out_x";
            1: return "out_y";
            2: return "out_z";
            default: return "energy_out";
        endcase
    endfunction

    function automatic void set_identity();
        for (int i = 0; i < lbfm_pkg::NCOEF; i++)
            coef[i] = 0;
        coef[0] = 64'sd1 <<< lbfm_pkg::CF;
        coef[4] = 64'sd1 <<< lbfm_pkg::CF;
        coef[5] = 64'sd1 <<< lbfm_pkg::CF;
        coef[6] = 64'sd1 <<< lbfm_pkg::CF;
    endfunction

    function automatic void rebuild_matrix();
        longint unsigned b2, d, g2, g, k, rem, bitv, r, v;
        longint q;
        int pi [3];
        int pj [3];
        pi = '{0, 0, 1};
        pj = '{1, 2, 2};
        b2 = 0;
        for (int i = 0; i < 3; i++)
            b2 += longint'(beta_val[i] * beta_val[i]);
        if (b2 >= ONE60)
        begin
            beta_good = 1'b0;
            set_identity();
            return;
        end
        beta_good = 1'b1;
        d = ONE60 - b2;
        if (d < (64'd1 << 38))
            g2 = 64'd1 << 62;
        else
        begin
            g2 = ONE60 / d;
            rem = ONE60 % d;
            for (int i = 0; i < 40; i++)
            begin
                rem = rem << 1;
                g2 = g2 << 1;
                if (rem >= d)
                begin
                    rem -= d;
                    g2 |= 64'd1;
                end
            end
        end
        // bitwise integer square root
        v = g2;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        g = r;
        k = g2 / (g + (64'd1 << lbfm_pkg::CF));
        coef[0] = clamp32(longint'(g));
        for (int i = 0; i < 3; i++)
        begin
            q = rnd_shift(beta_val[i] * beta_val[i], 30);
            coef[1+i] = clamp32(-rnd_shift(longint'(g) * beta_val[i], 30));
            coef[4+i] = clamp32((64'sd1 <<< lbfm_pkg::CF) + rnd_shift(longint'(k) * q, 30));
        end
        for (int i = 0; i < 3; i++)
        begin
            q = rnd_shift(beta_val[pi[i]] * beta_val[pj[i]], 30);
            coef[7+i] = clamp32(rnd_shift(longint'(k) * q, 30));
        end
    endfunction

    function automatic boosted_t boost_particle(particle_t p);
        boosted_t res;
        longint hi, lo, pv, pl, v;
        res.tag = p.tag;
        res.sat = 1'b0;
        res.invalid = ~beta_good;
        if (!beta_good)
        begin
            res.mom = p.mom;
            return res;
        end
        for (int r = 0; r < 4; r++)
        begin
            hi = 0;
            lo = 0;
            for (int c = 0; c < 4; c++)
            begin
                pv = longint'(p.mom[c]);
                pl = pv & 64'sh00000000000FFFFF;
                hi += (pv >>> lbfm_pkg::CF) * coef[lbfm_pkg::ROW_IDX[r][c]];
                lo += pl * coef[lbfm_pkg::ROW_IDX[r][c]];
            end
            v = hi + rnd_shift(lo, lbfm_pkg::CF);
            if (v != clamp32(v))
                res.sat = 1'b1;
            res.mom[r] = MW'(clamp32(v));
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sender_dense || sel < 60)
            return 0;
        if (sel < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_particles.size() > 0)
            begin
                shown_particle = pending_particles.pop_front();
                s_axis_tdata <= {shown_particle.tag, shown_particle.mom[3], shown_particle.mom[2],
                                 shown_particle.mom[1], shown_particle.mom[0]};
                s_axis_tvalid <= 1'b1;
                gap_left = pick_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (sender_dense)
            m_axis_tready <= 1'b1;
        else
        begin
            if ($urandom_range(0, 99) < 4)
                hold_left = $urandom_range(8, 40);
            m_axis_tready <= ($urandom_range(0, 99) < 75);
        end
    end

    // input capture and output check
    always @(posedge clk)
    begin
        boosted_t exp_b;
        logic signed [MW-1:0] got;
        in_taken = s_axis_tvalid && s_axis_tready;
        if (in_taken)
            expected_boosts.insert(expected_boosts.size(), boost_particle(shown_particle));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_boosts.size() == 0)
            begin
                $error("unexpected output beat");
                fail_seen = 1'b1;
            end
            else
            begin
                exp_b = expected_boosts.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    got = m_axis_tdata[i*MW +: MW];
                    if (got !== exp_b.mom[i])
                    begin
                        $error("%s: expected %0d, got %0d", comp_name(i), exp_b.mom[i], got);
                        fail_seen = 1'b1;
                    end
                end
                if (m_axis_tdata[4*MW +: TGW] !== exp_b.tag)
                begin
                    $error("tag_out: expected %0h, got %0h", exp_b.tag,
                           m_axis_tdata[4*MW +: TGW]);
                    fail_seen = 1'b1;
                end
                if (m_axis_tuser[0] !== exp_b.invalid)
                begin
                    $error("beta_invalid: expected %0b, got %0b", exp_b.invalid, m_axis_tuser[0]);
                    fail_seen = 1'b1;
                end
                if (m_axis_tuser[1] !== exp_b.sat)
                begin
                    $error("saturated: expected %0b, got %0b", exp_b.sat, m_axis_tuser[1]);
                    fail_seen = 1'b1;
                end
            end
        end
    end

    task automatic queue_particle(longint x, longint y, longint z, longint e, int tag);
        particle_t p;
        p.mom[0] = MW'(x);
        p.mom[1] = MW'(y);
        p.mom[2] = MW'(z);
        p.mom[3] = MW'(e);
        p.tag = TGW'(tag);
        pending_particles.insert(pending_particles.size(), p);
    endtask

    function automatic longint rand_mom();
        if ($urandom_range(0, 99) < 70)
            return longint'($signed($urandom_range(0, 32'h01FFFFFF))) - 64'sh01000000;
        return longint'($signed($urandom()));
    endfunction

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            queue_particle(rand_mom(), rand_mom(), rand_mom(), rand_mom(), $urandom_range(0, 65535));
    endtask

    task automatic wait_idle();
        while (pending_particles.size() > 0 || expected_boosts.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_beta(logic [lbfm_pkg::CFG_IDX_W-1:0] idx, longint val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[lbfm_pkg::BETA_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx <= lbfm_pkg::REG_BETA_Z)
        begin
            beta_val[idx] = longint'($signed(val[lbfm_pkg::BETA_W-1:0]));
            rebuild_matrix();
        end
        repeat (3) @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic set_beta(longint bx, longint by, longint bz);
        wait_idle();
        write_beta(lbfm_pkg::REG_BETA_X, bx);
        write_beta(lbfm_pkg::REG_BETA_Y, by);
        write_beta(lbfm_pkg::REG_BETA_Z, bz);
    endtask

    initial
    begin
        longint mx, mn;
        mx = 64'sd2147483647;
        mn = -64'sd2147483648;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_taken = 1'b0;
        fail_seen = 1'b0;
        sender_dense = 1'b0;
        gap_left = 0;
        hold_left = 0;
        hold_request = 0;
        for (int i = 0; i < 3; i++)
            beta_val[i] = 0;
        beta_good = 1'b1;
        set_identity();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes under the reset identity
        queue_particle(0, 0, 0, 0, 0);
        queue_particle(mx, mx, mx, mx, 16'hFFFF);
        queue_particle(mn, mn, mn, mn, 0);
        queue_particle(mx, mn, mx, mn, 16'h5A5A);
        queue_particle(mn, mx, mn, mx, 16'hA5A5);
        queue_particle(1, -1, 65536, -65536, 1);
        queue_particle(mx, 0, 0, 0, 2);
        queue_particle(0, mn, 0, 0, 3);
        queue_particle(0, 0, mx, 0, 4);
        queue_particle(0, 0, 0, mn, 5);
        queue_random(10);

        // typical boost, long receiver hold while the block fills
        set_beta(536870912, 322122547, -214748365);
        queue_particle(mx, mx, mx, mx, 7);
        queue_particle(mn, mn, mn, mn, 8);
        hold_request = 300;
        sender_dense = 1'b1;
        queue_random(200);
        wait_idle();
        sender_dense = 1'b0;

        // extreme gamma at both signs
        set_beta(1073741823, 0, 0);
        queue_random(100);
        set_beta(0, -1073741823, 0);
        queue_random(100);

        // speed at or above light
        set_beta(-1073741824, 0, 0);
        queue_particle(mx, mn, 0, 1, 9);
        queue_random(150);
        set_beta(1073741823, 1073741823, 1073741823);
        queue_random(60);

        // back to zero beta, sender pause in the middle
        set_beta(0, 0, 0);
        queue_random(100);
        wait_idle();
        queue_random(100);

        // out of range index is ignored
        set_beta(0, 0, 858993459);
        wait_idle();
        write_beta(2'd3, -536870912);
        queue_random(150);

        for (int ph = 0; ph < 6; ph++)
        begin
            set_beta(longint'($signed($urandom_range(0, 32'h3FFFFFFF))) - 64'sd536870912,
                     longint'($signed($urandom_range(0, 32'h3FFFFFFF))) - 64'sd536870912,
                     longint'($signed($urandom_range(0, 32'h3FFFFFFF))) - 64'sd536870912);
            queue_random(140);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (!fail_seen)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: lorentz_boost_four_momentum.f
sv/lbfm_pkg.sv
sv/lorentz_boost_four_momentum.sv
verif/lorentz_boost_four_momentum_tb.sv
